// ===== design/rtc_pkg.sv =====
`default_nettype none
package rtc_pkg;

    localparam int ID_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W        = 5;
    localparam int DOT_W         = 66;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_MIN_DIST = 3'd6;
    localparam logic [2:0] REG_ANY_HIT  = 3'd7;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic [15:0]        tri_id;
        logic               last_tri;
    } t_tri;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_distance;
        logic [15:0]        hit_id;
        logic [16:0]        bary_u;
        logic [16:0]        bary_v;
    } t_hit;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_MUL,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] limit;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [DOT_W-1:0] x);
        logic signed [DOT_W-1:0] hi;
        logic signed [DOT_W-1:0] lo;
        hi = DOT_W'(64'sh7FFFFFFF);
        lo = -DOT_W'(64'sh80000000);
        if (x > hi) return 32'sh7FFFFFFF;
        if (x < lo) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/ray_triangle_closest_hit.sv =====
// works in order through the edges, 24 shared multiplies with the determinant check,
//   three divisions on one restoring divider, then the update; a near-zero determinant
//   goes from the check to the update, and a failed range test skips the divisions
// ready only while idle, so one triangle is finished before the next is taken; the last
//   triangle then loads the result register, waiting while an earlier result is still held
// reset: synchronous active low; ray registers to origin 0, direction +z, state cleared
`default_nettype none
module ray_triangle_closest_hit #(
    parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire rtc_pkg::t_tri         i_tri,
    output logic                       o_valid,
    input  wire                        i_ready,
    output rtc_pkg::t_hit              o_hit,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [rtc_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int W = rtc_pkg::DOT_W;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic signed [31:0] w_reg [7];
    logic               w_any;

    rtc_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_reg(w_reg), .o_any_hit(w_any)
    );

    rtc_pkg::t_state r_st, n_st;
    rtc_pkg::t_tri   r_tri;
    logic signed [31:0] r_e1 [3], r_e2 [3], r_tv [3], r_p [3], r_q [3];
    logic signed [W-1:0] r_acc, r_det, r_un, r_vn, r_tn;
    logic [4:0] r_k;
    logic [1:0] r_dk;
    logic [63:0] r_adet, r_u, r_v, r_mag;
    logic        r_neg;
    logic        r_have;
    logic signed [31:0] r_best;
    logic [15:0] r_bid;
    logic [16:0] r_bu, r_bv;
    logic        r_ovalid;
    rtc_pkg::t_hit r_out;

    rtc_pkg::t_div_req w_req;
    rtc_pkg::t_div_rsp w_rsp;

    rtc_div #(.FRAC_BITS(FRAC_BITS)) u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    // operand select for the shared multiplier, one product per step
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [W-1:0] w_sh;
    always_comb begin
        w_ma = '0; w_mb = '0;
        case (r_k)
            5'd0:  begin w_ma = w_reg[4];   w_mb = r_e2[2]; end
            5'd1:  begin w_ma = w_reg[5];   w_mb = r_e2[1]; end
            5'd2:  begin w_ma = w_reg[5];   w_mb = r_e2[0]; end
            5'd3:  begin w_ma = w_reg[3];   w_mb = r_e2[2]; end
            5'd4:  begin w_ma = w_reg[3];   w_mb = r_e2[1]; end
            5'd5:  begin w_ma = w_reg[4];   w_mb = r_e2[0]; end
            5'd6:  begin w_ma = r_e1[0]; w_mb = r_p[0]; end
            5'd7:  begin w_ma = r_e1[1]; w_mb = r_p[1]; end
            5'd8:  begin w_ma = r_e1[2]; w_mb = r_p[2]; end
            5'd9:  begin w_ma = r_tv[1]; w_mb = r_e1[2]; end
            5'd10: begin w_ma = r_tv[2]; w_mb = r_e1[1]; end
            5'd11: begin w_ma = r_tv[2]; w_mb = r_e1[0]; end
            5'd12: begin w_ma = r_tv[0]; w_mb = r_e1[2]; end
            5'd13: begin w_ma = r_tv[0]; w_mb = r_e1[1]; end
            5'd14: begin w_ma = r_tv[1]; w_mb = r_e1[0]; end
            5'd15: begin w_ma = r_tv[0]; w_mb = r_p[0]; end
            5'd16: begin w_ma = r_tv[1]; w_mb = r_p[1]; end
            5'd17: begin w_ma = r_tv[2]; w_mb = r_p[2]; end
            5'd18: begin w_ma = w_reg[3]; w_mb = r_q[0]; end
            5'd19: begin w_ma = w_reg[4]; w_mb = r_q[1]; end
            5'd20: begin w_ma = w_reg[5]; w_mb = r_q[2]; end
            5'd21: begin w_ma = r_e2[0]; w_mb = r_q[0]; end
            5'd22: begin w_ma = r_e2[1]; w_mb = r_q[1]; end
            5'd23: begin w_ma = r_e2[2]; w_mb = r_q[2]; end
            default: ;
        endcase
        w_prod = w_ma * w_mb;
        w_sh   = W'(w_prod >>> FRAC_BITS);
    end

    // product of the previous step, registered before it is accumulated
    logic signed [W-1:0] r_prod;
    logic [4:0]          r_pk;
    logic                r_pv;

    // first product of a cross pair adds, second subtracts then saturates
    logic signed [W-1:0] w_sum;
    logic                w_neg_term, w_cross_end, w_dot_end;
    always_comb begin
        w_neg_term  = (r_pk < 5'd6 && r_pk[0]) ||
                      (r_pk >= 5'd9 && r_pk < 5'd15 && !r_pk[0]);
        w_cross_end = w_neg_term;
        w_dot_end   = (r_pk == 5'd8) || (r_pk == 5'd17) || (r_pk == 5'd20) || (r_pk == 5'd23);
        w_sum = w_neg_term ? r_acc - r_prod : r_acc + r_prod;
    end

    // det magnitude and the near-zero test
    logic [W-1:0] w_adet;
    logic [W+20-1:0] w_scaled;
    logic         w_small;
    always_comb begin
        w_adet   = r_det[W-1] ? W'(-r_det) : W'(r_det);
        w_scaled = (W+20)'(w_adet) * (W+20)'(1000000);
        w_small  = w_scaled < (W+20)'(ONE);
    end

    logic signed [W-1:0] w_un, w_vn, w_tn;
    logic                w_range_bad;
    always_comb begin
        w_un = r_det[W-1] ? -r_un : r_un;
        w_vn = r_det[W-1] ? -r_vn : r_vn;
        w_tn = r_det[W-1] ? -r_tn : r_tn;
        w_range_bad = w_un[W-1] || w_vn[W-1] || (W'(w_un) > w_adet) ||
                      ((W+1)'(w_un) + (W+1)'(w_vn) > (W+1)'(w_adet));
    end

    logic signed [32:0] w_t;
    logic               w_take;
    always_comb begin
        w_t = r_neg ? -$signed({1'b0, r_mag[31:0]}) : $signed({1'b0, r_mag[31:0]});
        w_take = (w_t > 33'(w_reg[6])) &&
                 (w_any ? !r_have : (!r_have || w_t < 33'(r_best)));
    end

    // result register loads once the previous result has gone
    logic w_out_go;
    assign w_out_go = (r_st == rtc_pkg::ST_OUT) && (!r_ovalid || i_ready);

    // division request (numerator and limit) for the division being started, and next-state logic
    logic [1:0] w_dsel;
    always_comb begin
        n_st = r_st;
        w_dsel = (r_st == rtc_pkg::ST_DIV_DONE) ? r_dk + 2'd1 : r_dk;
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = r_adet;
        w_req.limit = ONE;
        case (w_dsel)
            2'd0: w_req.num = 64'(w_un);
            2'd1: w_req.num = 64'(w_vn);
            default: begin
                w_req.num   = r_tn[W-1] ^ r_det[W-1] ? 64'(-w_tn) : 64'(w_tn);
                w_req.limit = (r_tn[W-1] ^ r_det[W-1]) && (w_tn != '0) ?
                              64'h80000000 : 64'h7FFFFFFF;
            end
        endcase
        case (r_st)
            rtc_pkg::ST_IDLE:  if (i_valid && o_ready) n_st = rtc_pkg::ST_EDGE;
            rtc_pkg::ST_EDGE:  n_st = rtc_pkg::ST_MUL;
            rtc_pkg::ST_MUL: begin
                if (r_pv && r_pk == 5'd8) n_st = rtc_pkg::ST_CHECK;
                else if (r_pv && r_pk == 5'd23) n_st = rtc_pkg::ST_DIV_START;
            end
            rtc_pkg::ST_CHECK:
                n_st = w_small ? rtc_pkg::ST_UPDATE : rtc_pkg::ST_MUL;
            rtc_pkg::ST_DIV_START: begin
                if (w_range_bad) n_st = rtc_pkg::ST_UPDATE;
                else begin
                    w_req.start = 1'b1;
                    n_st = rtc_pkg::ST_DIV_RUN;
                end
            end
            rtc_pkg::ST_DIV_RUN: if (w_rsp.done) n_st = rtc_pkg::ST_DIV_DONE;
            rtc_pkg::ST_DIV_DONE: begin
                if (r_dk == 2'd2) n_st = rtc_pkg::ST_UPDATE;
                else begin
                    w_req.start = 1'b1;
                    n_st = rtc_pkg::ST_DIV_RUN;
                end
            end
            rtc_pkg::ST_UPDATE:
                n_st = r_tri.last_tri ? rtc_pkg::ST_OUT : rtc_pkg::ST_IDLE;
            rtc_pkg::ST_OUT:   n_st = w_out_go ? rtc_pkg::ST_IDLE : rtc_pkg::ST_OUT;
            default:           n_st = rtc_pkg::ST_IDLE;
        endcase
    end

    assign o_ready = (r_st == rtc_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_hit   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= rtc_pkg::ST_IDLE;
            r_have   <= 1'b0;
            r_best   <= 32'sh7FFFFFFF;
            r_bid    <= '0;
            r_bu     <= '0;
            r_bv     <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_k      <= '0;
            r_dk     <= '0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && i_ready && !w_out_go) r_ovalid <= 1'b0;
            case (r_st)
                rtc_pkg::ST_IDLE: if (i_valid && o_ready) r_tri <= i_tri;
                rtc_pkg::ST_EDGE: begin
                    r_e1[0] <= rtc_pkg::sat32(W'(r_tri.b_x) - W'(r_tri.a_x));
                    r_e1[1] <= rtc_pkg::sat32(W'(r_tri.b_y) - W'(r_tri.a_y));
                    r_e1[2] <= rtc_pkg::sat32(W'(r_tri.b_z) - W'(r_tri.a_z));
                    r_e2[0] <= rtc_pkg::sat32(W'(r_tri.c_x) - W'(r_tri.a_x));
                    r_e2[1] <= rtc_pkg::sat32(W'(r_tri.c_y) - W'(r_tri.a_y));
                    r_e2[2] <= rtc_pkg::sat32(W'(r_tri.c_z) - W'(r_tri.a_z));
                    r_tv[0] <= rtc_pkg::sat32(W'(w_reg[0]) - W'(r_tri.a_x));
                    r_tv[1] <= rtc_pkg::sat32(W'(w_reg[1]) - W'(r_tri.a_y));
                    r_tv[2] <= rtc_pkg::sat32(W'(w_reg[2]) - W'(r_tri.a_z));
                    r_k   <= '0;
                    r_pv  <= 1'b0;
                    r_acc <= '0;
                    r_dk  <= '0;
                end
                rtc_pkg::ST_MUL: begin
                    // issue stalls after det until the check is done
                    r_pv   <= !(r_pv && r_pk == 5'd8) && r_k <= 5'd23;
                    r_prod <= w_sh;
                    r_pk   <= r_k;
                    if (!(r_pv && r_pk == 5'd8) && r_k <= 5'd23) r_k <= r_k + 1'b1;
                    if (r_pv) begin
                        if (w_cross_end || w_dot_end) r_acc <= '0;
                        else r_acc <= w_sum;
                        if (w_cross_end) begin
                            case (r_pk)
                                5'd1:  r_p[0] <= rtc_pkg::sat32(w_sum);
                                5'd3:  r_p[1] <= rtc_pkg::sat32(w_sum);
                                5'd5:  r_p[2] <= rtc_pkg::sat32(w_sum);
                                5'd10: r_q[0] <= rtc_pkg::sat32(w_sum);
                                5'd12: r_q[1] <= rtc_pkg::sat32(w_sum);
                                5'd14: r_q[2] <= rtc_pkg::sat32(w_sum);
                                default: ;
                            endcase
                        end
                        case (r_pk)
                            5'd8:  r_det <= w_sum;
                            5'd17: r_un  <= w_sum;
                            5'd20: r_vn  <= w_sum;
                            5'd23: r_tn  <= w_sum;
                            default: ;
                        endcase
                    end
                end
                rtc_pkg::ST_CHECK: begin
                    r_adet <= w_adet[63:0];
                    r_pv   <= 1'b0;
                end
                rtc_pkg::ST_DIV_DONE: begin
                    case (r_dk)
                        2'd0: r_u <= w_rsp.quo;
                        2'd1: r_v <= w_rsp.quo;
                        default: begin
                            r_mag <= w_rsp.quo;
                            r_neg <= r_tn[W-1] ^ r_det[W-1];
                        end
                    endcase
                    r_dk <= r_dk + 1'b1;
                end
                rtc_pkg::ST_UPDATE: begin
                    if (r_dk == 2'd3 && w_take) begin
                        r_have <= 1'b1;
                        r_best <= w_t[31:0];
                        r_bid  <= 16'(r_tri.tri_id);
                        r_bu   <= r_u[16:0];
                        r_bv   <= r_v[16:0];
                    end
                end
                rtc_pkg::ST_OUT: begin
                    if (w_out_go) begin
                        r_ovalid           <= 1'b1;
                        r_out.hit          <= r_have;
                        r_out.hit_distance <= r_have ? r_best : '0;
                        r_out.hit_id       <= r_have ? r_bid : '0;
                        r_out.bary_u       <= r_have ? r_bu : '0;
                        r_out.bary_v       <= r_have ? r_bv : '0;
                        r_have <= 1'b0;
                        r_best <= 32'sh7FFFFFFF;
                        r_bid  <= '0;
                        r_bu   <= '0;
                        r_bv   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/rtc_div.sv =====
`default_nettype none
module rtc_div #(
    parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire rtc_pkg::t_div_req  i_req,
    output rtc_pkg::t_div_rsp       o_rsp
);
    // restoring divider, one quotient bit a cycle, integer part then fraction
    localparam int STEPS = 64 + FRAC_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [63:0]    r_num;
    logic [64:0]    r_rem;
    logic [63:0]    r_den;
    logic [63:0]    r_lim;
    logic [STEPS-1:0] r_quo;
    logic [64:0]    n_rem;
    logic           n_bit;

    always_comb begin
        n_rem = {r_rem[63:0], r_num[63]};
        n_bit = 1'b0;
        if (n_rem >= {1'b0, r_den}) begin
            n_rem = n_rem - {1'b0, r_den};
            n_bit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_lim  <= i_req.limit;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[62:0], 1'b0};
                r_quo <= {r_quo[STEPS-2:0], n_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // any bit at 64 or above means the quotient exceeds every limit
    always_comb begin
        o_rsp.done = r_done;
        if ((r_quo >> 64) != '0 || r_quo[63:0] > r_lim) begin
            o_rsp.quo = r_lim;
        end else begin
            o_rsp.quo = r_quo[63:0];
        end
    end
endmodule
`default_nettype wire

// ===== design/rtc_cfg.sv =====
`default_nettype none
module rtc_cfg #(
    parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [rtc_pkg::ADDR_W-1:0]      paddr,
    input  wire [31:0]                     pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic signed [31:0]             o_reg [7],
    output logic                           o_any_hit
);
    logic signed [31:0] r_reg [7];
    logic               r_any;
    logic [2:0]         w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 7; i++)
                r_reg[i] <= (3'(i) == rtc_pkg::REG_DIR_Z) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            r_any <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (w_idx == rtc_pkg::REG_ANY_HIT) r_any <= pwdata[0];
            else r_reg[w_idx] <= pwdata;
        end
    end

    always_comb begin
        if (w_idx == rtc_pkg::REG_ANY_HIT) prdata = {31'd0, r_any};
        else prdata = r_reg[w_idx];
    end

    assign o_reg     = r_reg;
    assign o_any_hit = r_any;
endmodule
`default_nettype wire

// ===== design/rtc_checker.sv =====
`default_nettype none
module rtc_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_valid,
    input wire                o_ready,
    input wire                o_valid,
    input wire                i_ready,
    input wire rtc_pkg::t_hit o_hit
);
    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && !i_ready |=> o_valid && $stable(o_hit);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_nohit_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && !o_hit.hit |-> o_hit.hit_id == '0 && o_hit.hit_distance == '0;
    endproperty
    a_nohit: assert property (p_nohit_zero) else $error("miss carries data");

    property p_bary;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid |-> o_hit.bary_u <= 17'h10000 && o_hit.bary_v <= 17'h10000;
    endproperty
    a_bary: assert property (p_bary) else $error("barycentric out of range");

    property p_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_valid && o_ready |=> !o_ready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready after transfer");
endmodule

bind ray_triangle_closest_hit rtc_checker u_rtc_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_hit
);
`default_nettype wire
